/* rtl/core/gh_pkg.sv */
// ----------------------------------------------------------------------------
// gh_pkg: shared constants and types for the geohash encoder
// Coordinate format, quantizer constants, code word layout and the base32
// alphabet used by the geohash encoder modules.
// ----------------------------------------------------------------------------
package gh_pkg;

    // Coordinate format and code length limits.
    localparam int FRAC_BITS  = 23;
    localparam int MAX_CHARS  = 12;
    localparam int GROUP_BITS = 5;
    localparam int LEN_W      = 4;
    localparam int LON_W      = 32;
    localparam int LAT_W      = 31;
    localparam int CHAR_W     = 7;

    // Each coordinate is quantized to the finest grid that any length needs;
    // shorter codes keep only the top bits of it.
    localparam int Q_BITS    = (GROUP_BITS * MAX_CHARS + 1) / 2;
    localparam int CODE_BITS = 2 * Q_BITS;

    // Offsets in degrees; spans are twice these (360 = 8 * 45, 180 = 4 * 45).
    localparam int LON_OFF_DEG = 180;
    localparam int LAT_OFF_DEG = 90;

    localparam logic signed [LON_W-1:0] LON_BIAS = LON_W'(LON_OFF_DEG << FRAC_BITS);
    localparam logic signed [LAT_W-1:0] LAT_BIAS = LAT_W'(LAT_OFF_DEG << FRAC_BITS);

    // Division by 45 through a reciprocal: floor(y / 45) = (y * DIV_MAGIC) >> DIV_K
    // holds exactly for every y below 45 * 2^Q_BITS.
    localparam int          DIV_K     = 42;
    localparam int          MAGIC_W   = 37;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 37'd97734366914;

    // Operand split for the partial products.
    localparam int X_W    = 32;
    localparam int HALF_W = X_W / 2;
    localparam int PART_W = HALF_W + MAGIC_W;
    localparam int PROD_W = X_W + MAGIC_W;

    // Longitude: q = sum * 2^(Q_BITS-FRAC_BITS) / (8 * 45).
    // Latitude:  q = sum * 2^(Q_BITS-FRAC_BITS) / (4 * 45).
    localparam int LON_SHIFT = DIV_K - (Q_BITS - FRAC_BITS - 3);
    localparam int LAT_SHIFT = DIV_K - (Q_BITS - FRAC_BITS - 2);

    // Interleaved code word and its character count.
    typedef struct packed {
        logic [CODE_BITS-1:0] word;
        logic [LEN_W-1:0]     len;
    } t_code;

    // Base32 geohash alphabet as ASCII codes.
    localparam logic [CHAR_W-1:0] ALPHABET [32] = '{
        7'd48,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,
        7'd56,  7'd57,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
        7'd104, 7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd114,
        7'd115, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122
    };

    localparam logic [CHAR_W-1:0] CHAR_LOW  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_HIGH = 7'd122;

endpackage

/* rtl/core/gh_pos_if.sv */
// ----------------------------------------------------------------------------
// gh_pos_if: position channel
// Carries one position and the requested code length per beat.
// ----------------------------------------------------------------------------
interface gh_pos_if
    import gh_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [LON_W-1:0] longitude;
    logic signed [LAT_W-1:0] latitude;
    logic [LEN_W-1:0]        length;

    modport source (output valid, output longitude, output latitude, output length,
                    input ready);
    modport sink   (input valid, input longitude, input latitude, input length,
                    output ready);
endinterface

/* rtl/core/gh_char_if.sv */
// ----------------------------------------------------------------------------
// gh_char_if: character channel
// Carries one geohash character and its end-of-code mark per beat.
// ----------------------------------------------------------------------------
interface gh_char_if
    import gh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/core/gh_quant.sv */
// ----------------------------------------------------------------------------
// gh_quant: coordinate quantizer and bit interleaver
// Three pipeline stages: offset add with range checks, split reciprocal
// multiplication, then recombination, saturation and interleaving.
// ----------------------------------------------------------------------------
module gh_quant
    import gh_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [LON_W-1:0] i_lon,
    input  logic signed [LAT_W-1:0] i_lat,
    input  logic [LEN_W-1:0]        i_len,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_code                   o_code
);

    // Stage A: biased coordinates and range flags.
    logic             r_a_valid;
    logic [X_W-1:0]   r_a_lon_x;
    logic [X_W-1:0]   r_a_lat_x;
    logic             r_a_lon_lo, r_a_lon_hi, r_a_lat_lo, r_a_lat_hi;
    logic [LEN_W-1:0] r_a_len;

    // Stage B: partial products.
    logic              r_b_valid;
    logic [PART_W-1:0] r_b_lon_hi_p, r_b_lon_lo_p, r_b_lat_hi_p, r_b_lat_lo_p;
    logic              r_b_lon_lo, r_b_lon_hi, r_b_lat_lo, r_b_lat_hi;
    logic [LEN_W-1:0]  r_b_len;

    // Stage C: finished code word.
    logic  r_c_valid;
    t_code r_c_code;

    logic rdy_a, rdy_b, rdy_c;

    logic [LON_W:0]         lon_sum;
    logic [LAT_W:0]         lat_sum;
    logic [PROD_W-1:0]      lon_prod, lat_prod;
    logic [Q_BITS-1:0]      lon_q, lat_q;
    logic [CODE_BITS-1:0]   word;

    assign rdy_c   = !r_c_valid || i_ready;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_c_valid;
    assign o_code  = r_c_code;

    assign lon_sum = {i_lon[LON_W-1], i_lon} + {LON_BIAS[LON_W-1], LON_BIAS};
    assign lat_sum = {i_lat[LAT_W-1], i_lat} + {LAT_BIAS[LAT_W-1], LAT_BIAS};

    assign lon_prod = {r_b_lon_hi_p, {HALF_W{1'b0}}} + PROD_W'(r_b_lon_lo_p);
    assign lat_prod = {r_b_lat_hi_p, {HALF_W{1'b0}}} + PROD_W'(r_b_lat_lo_p);

    always_comb begin
        if (r_b_lon_lo) begin
            lon_q = '0;
        end else if (r_b_lon_hi) begin
            lon_q = '1;
        end else begin
            lon_q = lon_prod[LON_SHIFT +: Q_BITS];
        end
        if (r_b_lat_lo) begin
            lat_q = '0;
        end else if (r_b_lat_hi) begin
            lat_q = '1;
        end else begin
            lat_q = lat_prod[LAT_SHIFT +: Q_BITS];
        end
        // Longitude bit leads each pair, most significant pair first.
        for (int i = 0; i < Q_BITS; i++) begin
            word[CODE_BITS-1-2*i] = lon_q[Q_BITS-1-i];
            word[CODE_BITS-2-2*i] = lat_q[Q_BITS-1-i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end

        if (rdy_a && i_valid) begin
            r_a_lon_x  <= lon_sum[X_W-1:0];
            r_a_lat_x  <= X_W'(lat_sum[LAT_W-1:0]);
            r_a_lon_lo <= (i_lon <= -LON_BIAS);
            r_a_lon_hi <= (i_lon >= LON_BIAS);
            r_a_lat_lo <= (i_lat <= -LAT_BIAS);
            r_a_lat_hi <= (i_lat >= LAT_BIAS);
            r_a_len    <= i_len;
        end

        if (rdy_b && r_a_valid) begin
            r_b_lon_hi_p <= PART_W'(r_a_lon_x[X_W-1:HALF_W]) * PART_W'(DIV_MAGIC);
            r_b_lon_lo_p <= PART_W'(r_a_lon_x[HALF_W-1:0]) * PART_W'(DIV_MAGIC);
            r_b_lat_hi_p <= PART_W'(r_a_lat_x[X_W-1:HALF_W]) * PART_W'(DIV_MAGIC);
            r_b_lat_lo_p <= PART_W'(r_a_lat_x[HALF_W-1:0]) * PART_W'(DIV_MAGIC);
            r_b_lon_lo   <= r_a_lon_lo;
            r_b_lon_hi   <= r_a_lon_hi;
            r_b_lat_lo   <= r_a_lat_lo;
            r_b_lat_hi   <= r_a_lat_hi;
            r_b_len      <= r_a_len;
        end

        if (rdy_c && r_b_valid) begin
            r_c_code.word <= word;
            r_c_code.len  <= r_b_len;
        end
    end

endmodule

/* rtl/core/gh_serial.sv */
// ----------------------------------------------------------------------------
// gh_serial: character serializer
// Holds one code word and sends its top len five-bit groups, most significant
// first, as geohash characters, one beat per cycle while the output is ready.
// ----------------------------------------------------------------------------
module gh_serial
    import gh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_code i_code,
    gh_char_if.source o_char
);

    logic                 r_busy, n_busy;
    logic [CODE_BITS-1:0] r_word, n_word;
    logic [LEN_W-1:0]     r_left, n_left;

    logic fire, at_last, load;

    assign at_last = (r_left == '0);
    assign fire    = r_busy && o_char.ready;
    assign o_ready = !r_busy || (fire && at_last);
    assign load    = i_valid && o_ready;

    assign o_char.valid     = r_busy;
    assign o_char.character = ALPHABET[r_word[CODE_BITS-1 -: GROUP_BITS]];
    assign o_char.last      = at_last;

    always_comb begin
        n_busy = r_busy;
        n_word = r_word;
        n_left = r_left;
        if (load) begin
            n_busy = 1'b1;
            n_word = i_code.word;
            n_left = i_code.len - LEN_W'(1);
        end else if (fire) begin
            if (at_last) begin
                n_busy = 1'b0;
            end else begin
                n_word = r_word << GROUP_BITS;
                n_left = r_left - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_word <= n_word;
        r_left <= n_left;
    end

endmodule

/* rtl/core/geohash_encoder.sv */
// ----------------------------------------------------------------------------
// geohash_encoder: base32 geohash encoder
// Turns one fixed-point position into a geohash string of 1 to 12 characters.
// ----------------------------------------------------------------------------
// A position beat carries longitude and latitude in degrees as signed fixed
// point with 23 fraction bits, plus a character count; a count of zero is
// taken as one and a count above twelve as twelve. The block answers with one
// character beat per geohash character, most significant first, with last set
// on the final one. Coordinates at or above +180 / +90 land in the top cell and
// those at or below -180 / -90 in cell zero. The output serializer holds one
// position until all of its characters are out and loads the next as the last
// one is taken. Positions are taken every cycle until the four-deep front
// pipeline (input register, offset stage, multiply stage, interleave stage) is
// full; an accepted beat passes these stages and then the serializer register
// before its first character appears. The quantizer computes every coordinate
// to 30 bits through a reciprocal multiplication by 1/45, and the serializer
// sends only the top bits that the requested length needs, so there is no
// variable shift in the path.
// ----------------------------------------------------------------------------
module geohash_encoder
    import gh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    gh_pos_if.sink    i_pos,
    gh_char_if.source o_char
);

    // Input register: holds the accepted position with its count clamped.
    logic                    r_valid;
    logic signed [LON_W-1:0] r_lon;
    logic signed [LAT_W-1:0] r_lat;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        len_clamped;

    // Quantizer to serializer handoff.
    logic  q_ready;
    logic  q_valid;
    logic  s_ready;
    t_code q_code;

    // Zero means one character; anything above the maximum is cut to it.
    always_comb begin
        if (i_pos.length == '0) begin
            len_clamped = LEN_W'(1);
        end else if (i_pos.length > LEN_W'(MAX_CHARS)) begin
            len_clamped = LEN_W'(MAX_CHARS);
        end else begin
            len_clamped = i_pos.length;
        end
    end

    // The input register frees up as soon as the quantizer takes its content,
    // so a new beat can land in the same cycle.
    assign i_pos.ready = !r_valid || q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pos.ready) begin
            r_valid <= i_pos.valid;
        end
        if (i_pos.ready && i_pos.valid) begin
            r_lon <= i_pos.longitude;
            r_lat <= i_pos.latitude;
            r_len <= len_clamped;
        end
    end

    gh_quant u_quant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid),
        .o_ready (q_ready),
        .i_lon   (r_lon),
        .i_lat   (r_lat),
        .i_len   (r_len),
        .o_valid (q_valid),
        .i_ready (s_ready),
        .o_code  (q_code)
    );

    gh_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (s_ready),
        .i_code  (q_code),
        .o_char  (o_char)
    );

`ifndef SYNTHESIS
    // A taken character that is not the last must be followed by another.
    a_more_after_non_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char.valid && o_char.ready && !o_char.last) |=> o_char.valid)
        else $error("character stream ended without last");

    // A one-character code loaded into the serializer is marked last at once.
    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && s_ready && q_code.len == LEN_W'(1)) |=> (o_char.valid && o_char.last))
        else $error("single-character code not marked last");

    // Every character shown is drawn from the geohash alphabet range.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid |-> (o_char.character >= CHAR_LOW && o_char.character <= CHAR_HIGH))
        else $error("character outside the geohash alphabet");

    // Nothing comes out in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_char.valid)
        else $error("output valid right after reset");
`endif

endmodule

/* bench/tb_geohash_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_geohash_encoder: self-checking bench for the geohash encoder
// Feeds positions and code lengths through the position channel. Each
// accepted beat is encoded by an independent model in the bench, and every
// character beat is checked in order against the characters that model
// predicts. Both sides idle in random bursts. The receiver holds off for a
// long stretch once, and the sender waits twice for the output to drain.
// ----------------------------------------------------------------------------
module tb_geohash_encoder;
    import gh_pkg::*;

    // Coordinate format and code limits as the bench models them.
    localparam int FRACTION   = 23;
    localparam int CHAR_LIMIT = 12;
    localparam int GROUP_W    = 5;

    // Geohash base32 alphabet, first character in the top byte.
    localparam logic [8*32-1:0] GEO_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    // Fixed-point images of the range edges.
    localparam longint LON_EDGE = 64'sd1509949440;   // 180 degrees
    localparam longint LAT_EDGE = 64'sd754974720;    // 90 degrees

    // Run shape.
    localparam int RANDOM_COUNT = 360;
    localparam int DRAIN_AT_A   = 150;   // sender waits for an empty output before these
    localparam int DRAIN_AT_B   = 300;
    localparam int CALM_FROM    = 330;   // from here on nobody idles
    localparam int HOLD_AT      = 60;    // receiver holds off once this many positions went in
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 4000;  // watchdog: cycles without any accepted beat
    localparam int TAIL_CYCLES  = 24;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
        logic [LEN_W-1:0]        len;
        bit                      drain_first;
        bit                      calm;
    } t_position;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_char_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gh_pos_if  pos_bus ();
    gh_char_if char_bus ();

    geohash_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pos   (pos_bus),
        .o_char  (char_bus)
    );

    always #6 i_clk = ~i_clk;

    t_position  position_queue[$];
    t_char_beat expected_chars[$];
    int         mismatches = 0;
    int         positions_taken = 0;

    // ------------------------------------------------------------------------
    // Bench model of the encoder.
    // ------------------------------------------------------------------------

    // floor((v + offset) * 2^bits / span), clamped into 0 .. 2^bits - 1. Values
    // at or below the bottom edge land in cell zero; the top edge and beyond
    // would give 2^bits or more and are pulled back into the top cell.
    function automatic longint unsigned cell_index(input longint v, input int offset_deg,
                                                   input int span_deg, input int bits);
        longint          sum;
        longint unsigned top;
        longint unsigned q;
        sum = v + (longint'(offset_deg) <<< FRACTION);
        top = (64'd1 << bits) - 64'd1;
        if (sum <= 0)
            return 64'd0;
        q = (longint'(unsigned'(sum)) << bits) / (longint'(span_deg) << FRACTION);
        return (q > top) ? top : q;
    endfunction

    // Predicts the character beats of one accepted position and queues them.
    task automatic encode_position(input t_position p);
        int unsigned     n;
        int unsigned     total;
        int unsigned     lat_bits;
        int unsigned     lon_bits;
        int unsigned     li;
        int unsigned     ai;
        int unsigned     idx;
        longint unsigned col;
        longint unsigned row;
        longint unsigned code;
        t_char_beat      beat;
        // A count of zero means one character, anything above the limit is clamped.
        n = p.len;
        if (n < 1)
            n = 1;
        if (n > CHAR_LIMIT)
            n = CHAR_LIMIT;
        total    = n * GROUP_W;
        lat_bits = total / 2;
        lon_bits = total - lat_bits;
        col = cell_index(longint'(p.lon), 180, 360, lon_bits);
        row = cell_index(longint'(p.lat), 90, 180, lat_bits);
        // Interleave from the top down, longitude bit first.
        code = 64'd0;
        li   = lon_bits;
        ai   = lat_bits;
        for (int unsigned k = 0; k < total; k++) begin
            if (k % 2 == 0) begin
                li--;
                code = (code << 1) | ((col >> li) & 64'd1);
            end else begin
                ai--;
                code = (code << 1) | ((row >> ai) & 64'd1);
            end
        end
        for (int unsigned k = 0; k < n; k++) begin
            idx = int'((code >> (GROUP_W * (n - 1 - k))) & 64'd31);
            beat.character = GEO_ALPHABET[8 * (31 - idx) +: CHAR_W];
            beat.last      = (k + 1 == n);
            expected_chars.push_back(beat);
        end
    endtask

    task automatic note_mismatch(input string what, input t_char_beat want,
                                 input logic [CHAR_W-1:0] got_char, input logic got_last);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s: expected char '%c' (%0d) last %0d, got '%c' (%0d) last %0d",
                     $realtime, what, want.character, want.character, want.last,
                     got_char, got_char, got_last);
    endtask

    // Queues one position; its index decides whether the sender drains first
    // and whether idling is over by then.
    task automatic add_position(input longint lon, input longint lat, input int len);
        t_position p;
        p.lon         = lon[LON_W-1:0];
        p.lat         = lat[LAT_W-1:0];
        p.len         = len[LEN_W-1:0];
        p.drain_first = (position_queue.size() == DRAIN_AT_A) ||
                        (position_queue.size() == DRAIN_AT_B);
        p.calm        = (position_queue.size() >= CALM_FROM);
        position_queue.push_back(p);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers positions from the queue, predicts each accepted beat.
    // ------------------------------------------------------------------------
    int unsigned src_gap = 0;
    int unsigned src_mode = 1;
    int unsigned src_cycles = 0;
    bit          src_calm = 1'b0;

    always @(posedge i_clk) begin
        t_position p;
        if (!i_rst_n) begin
            pos_bus.valid     <= 1'b0;
            pos_bus.longitude <= '0;
            pos_bus.latitude  <= '0;
            pos_bus.length    <= '0;
        end else begin
            src_cycles++;
            // Idling comes and goes: some stretches have none, some a lot.
            if (src_cycles % 128 == 0)
                src_mode = $urandom_range(0, 3);
            if (pos_bus.valid && pos_bus.ready) begin
                p.lon = pos_bus.longitude;
                p.lat = pos_bus.latitude;
                p.len = pos_bus.length;
                encode_position(p);
                positions_taken <= positions_taken + 1;
            end
            // A new beat goes out only once the current one has been taken.
            if (!pos_bus.valid || pos_bus.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    pos_bus.valid <= 1'b0;
                end else if (position_queue.size() == 0) begin
                    pos_bus.valid <= 1'b0;
                end else if (position_queue[0].drain_first && expected_chars.size() != 0) begin
                    // Wait until every predicted character has come out.
                    pos_bus.valid <= 1'b0;
                end else if (!src_calm && src_mode != 0 && $urandom_range(0, 7) < src_mode) begin
                    // Start an idle burst with this cycle.
                    src_gap = $urandom_range(0, 5);
                    pos_bus.valid <= 1'b0;
                end else begin
                    p = position_queue.pop_front();
                    src_calm = p.calm;
                    pos_bus.longitude <= p.lon;
                    pos_bus.latitude  <= p.lat;
                    pos_bus.length    <= p.len;
                    pos_bus.valid     <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: drives ready with random stalls and checks every character beat.
    // ------------------------------------------------------------------------
    int unsigned sink_gap = 0;
    int unsigned sink_mode = 1;
    int unsigned sink_cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_char_beat want;
        if (!i_rst_n) begin
            char_bus.ready <= 1'b0;
        end else begin
            sink_cycles++;
            if (sink_cycles % 96 == 0)
                sink_mode = $urandom_range(0, 3);
            if (char_bus.valid && char_bus.ready) begin
                if (expected_chars.size() == 0) begin
                    want = '0;
                    note_mismatch("unexpected character beat", want,
                                  char_bus.character, char_bus.last);
                end else begin
                    want = expected_chars.pop_front();
                    if (char_bus.character !== want.character || char_bus.last !== want.last)
                        note_mismatch("character beat differs", want,
                                      char_bus.character, char_bus.last);
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                char_bus.ready <= 1'b0;
            end else if (!hold_done && positions_taken >= HOLD_AT) begin
                // One long hold-off, so the front pipeline fills and stalls the input.
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                char_bus.ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                char_bus.ready <= 1'b0;
            end else if (positions_taken < CALM_FROM && sink_mode != 0 &&
                         $urandom_range(0, 7) < sink_mode) begin
                sink_gap = $urandom_range(0, 5);
                char_bus.ready <= 1'b0;
            end else begin
                char_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run that stops moving fails.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pos_bus.valid && pos_bus.ready) || (char_bus.valid && char_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $realtime, IDLE_LIMIT);
                $display("geohash_encoder: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        longint lon;
        longint lat;
        int     len;
        int     pick;

        pos_bus.valid     = 1'b0;
        pos_bus.longitude = '0;
        pos_bus.latitude  = '0;
        pos_bus.length    = '0;
        char_bus.ready    = 1'b0;
        i_rst_n           = 1'b0;

        // Directed part: origin, both range edges, just inside and just
        // outside them, the extremes of the raw fields, then every length
        // code including zero and the ones above the limit.
        add_position(0, 0, 12);
        add_position(LON_EDGE, LAT_EDGE, 12);
        add_position(-LON_EDGE, -LAT_EDGE, 12);
        add_position(LON_EDGE - 1, LAT_EDGE - 1, 12);
        add_position(-LON_EDGE + 1, -LAT_EDGE + 1, 12);
        add_position(-LON_EDGE - 1, -LAT_EDGE - 1, 6);
        add_position(LON_EDGE + 1, LAT_EDGE + 1, 6);
        add_position(64'sh7FFF_FFFF, 64'sh3FFF_FFFF, 12);
        add_position(-64'sh8000_0000, -64'sh4000_0000, 12);
        for (int k = 0; k < 16; k++)
            add_position(64'sd112407347, 64'sd440401920, k);

        // Random part. Most positions are in range with legal lengths; the
        // rest hit the edges, whole degrees (exact cell boundaries), or take
        // raw field values and any length code.
        for (int k = 0; k < RANDOM_COUNT; k++) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, CHAR_LIMIT);
            if (pick < 60) begin
                lon = longint'($urandom_range(0, 32'd3019898880)) - LON_EDGE;
                lat = longint'($urandom_range(0, 32'd1509949440)) - LAT_EDGE;
            end else if (pick < 72) begin
                lon = (longint'($urandom_range(0, 360)) - 180) <<< FRACTION;
                lat = (longint'($urandom_range(0, 180)) - 90) <<< FRACTION;
            end else if (pick < 84) begin
                lon = ($urandom_range(0, 1) ? LON_EDGE : -LON_EDGE)
                      + longint'($urandom_range(0, 4)) - 2;
                lat = ($urandom_range(0, 1) ? LAT_EDGE : -LAT_EDGE)
                      + longint'($urandom_range(0, 4)) - 2;
            end else begin
                lon = longint'($urandom());
                lat = longint'($urandom());
                len = $urandom_range(0, 15);
            end
            add_position(lon, lat, len);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All positions accepted and every character back, then a tail in
        // which any stray beat would still be caught.
        while (position_queue.size() != 0 || pos_bus.valid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("geohash_encoder: match");
        end else begin
            $display("geohash_encoder: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/gh_pkg.sv
rtl/core/gh_pos_if.sv
rtl/core/gh_char_if.sv
rtl/core/gh_quant.sv
rtl/core/gh_serial.sv
rtl/core/geohash_encoder.sv
bench/tb_geohash_encoder.sv
